[src/fbw_pkg.sv]
// ----------------------------------------------------------------------------
// fbw_pkg: framebuffer window write port package
// Shared types, operation codes and reset constants for the window write port.
// ----------------------------------------------------------------------------
package fbw_pkg;

  localparam int FrameWidthDefault  = 160;
  localparam int FrameHeightDefault = 120;

  localparam int CoordW = 8;
  localparam int AddrW  = 15;
  localparam int DataW  = 8;
  localparam int OpW    = 2;

  typedef enum logic [OpW-1:0] {
    OP_PIXEL      = 2'd0,
    OP_SET_COL    = 2'd1,
    OP_SET_ROW    = 2'd2,
    OP_SET_EXTENT = 2'd3
  } op_t;

  // Reset values of the window registers.
  localparam logic [CoordW-1:0] LeftReset   = 8'd120;
  localparam logic [CoordW-1:0] TopReset    = 8'd160;
  localparam logic [CoordW-1:0] ExtentReset = 8'd0;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [DataW-1:0]  value;
  } item_t;

  typedef struct packed {
    logic              write_valid;
    logic [AddrW-1:0]  write_address;
    logic [DataW-1:0]  write_data;
    logic              clear_frame;
  } result_t;

  typedef struct packed {
    logic [AddrW-1:0]  linear_pointer;
    logic [CoordW-1:0] cursor_x;
    logic [CoordW-1:0] cursor_y;
    logic [CoordW-1:0] window_left;
    logic [CoordW-1:0] window_top;
    logic [CoordW-1:0] window_extent;
  } state_t;

endpackage

[src/fbw_in_if.sv]
// ----------------------------------------------------------------------------
// fbw_in_if: bus write channel
// Valid/ready channel that carries one host bus operation per transfer.
// ----------------------------------------------------------------------------
interface fbw_in_if;
  logic                      valid;
  logic                      ready;
  logic [fbw_pkg::OpW-1:0]   op;
  logic [fbw_pkg::DataW-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

[src/fbw_out_if.sv]
// ----------------------------------------------------------------------------
// fbw_out_if: frame store command channel
// Valid/ready channel that carries one frame store command per transfer.
// ----------------------------------------------------------------------------
interface fbw_out_if;
  logic                      valid;
  logic                      ready;
  logic                      write_valid;
  logic [fbw_pkg::AddrW-1:0] write_address;
  logic [fbw_pkg::DataW-1:0] write_data;
  logic                      clear_frame;

  modport source (output valid, output write_valid, output write_address,
                  output write_data, output clear_frame, input ready);
  modport sink   (input valid, input write_valid, input write_address,
                  input write_data, input clear_frame, output ready);
endinterface

[src/framebuffer_window_write_port.sv]
// ----------------------------------------------------------------------------
// framebuffer_window_write_port: host bus port into a byte framebuffer
// Turns bus operations into frame store write and clear commands.
// ----------------------------------------------------------------------------
// Flow: a transfer accepted into the input register passes through the step
// logic into the output register, from which its command transfers.
// Throughput: one transfer per cycle unless the output stalls; the input
// register, step logic and output register: two-stage pipeline, no iteration.
// Reset: synchronous, active low; it empties both stages and loads the window
// registers with their power-on values (origin column 120, row 160, extent 0).
module framebuffer_window_write_port #(
  parameter int FRAME_WIDTH  = fbw_pkg::FrameWidthDefault,
  parameter int FRAME_HEIGHT = fbw_pkg::FrameHeightDefault
) (
  input  logic clk,
  input  logic rst_n,
  fbw_in_if.sink    in_bus,
  fbw_out_if.source out_bus
);

  // Input stage: holds one bus operation until the step logic can use it.
  fbw_pkg::item_t   in_r;
  logic             in_valid_r;

  // Port state: linear pointer, cursor and window registers.
  fbw_pkg::state_t  st_r;
  fbw_pkg::state_t  st_nxt;

  // Output stage: one frame store command waiting for its transfer.
  fbw_pkg::result_t out_r;
  fbw_pkg::result_t res;
  logic             out_valid_r;

  logic             in_take;
  logic             advance;

  // The input stage moves forward whenever the output register is empty or
  // is emptied in the same cycle, so a stall downstream only holds what is
  // already in flight and transfers keep flowing back to back otherwise.
  assign advance       = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready  = !in_valid_r || advance;
  assign in_take       = in_bus.valid && in_bus.ready;

  fbw_step #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_step (
    .st     (st_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Control state and the window registers take the reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.linear_pointer <= '0;
      st_r.cursor_x       <= '0;
      st_r.cursor_y       <= '0;
      st_r.window_left    <= fbw_pkg::LeftReset;
      st_r.window_top     <= fbw_pkg::TopReset;
      st_r.window_extent  <= fbw_pkg::ExtentReset;
    end else begin
      if (in_bus.ready) begin
        in_valid_r <= in_bus.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.op    <= in_bus.op;
      in_r.value <= in_bus.value;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.write_valid   = out_r.write_valid;
  assign out_bus.write_address = out_r.write_address;
  assign out_bus.write_data    = out_r.write_data;
  assign out_bus.clear_frame   = out_r.clear_frame;

endmodule

[src/fbw_step.sv]
// ----------------------------------------------------------------------------
// fbw_step: one operation of the window write port
// Combinational next state and frame store command for one bus operation.
// ----------------------------------------------------------------------------
module fbw_step #(
  parameter int FRAME_WIDTH  = fbw_pkg::FrameWidthDefault,
  parameter int FRAME_HEIGHT = fbw_pkg::FrameHeightDefault
) (
  input  fbw_pkg::state_t  st,
  input  fbw_pkg::item_t   item,
  output fbw_pkg::state_t  st_nxt,
  output fbw_pkg::result_t res
);

  localparam int FrameSize = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int CW = fbw_pkg::CoordW;

  logic [CW:0]              next_x;
  logic [CW:0]              lim_x;
  logic [CW:0]              lim_y;
  logic [CW-1:0]            row_step;
  logic [15:0]              lp_inc;
  logic [15:0]              cursor_addr;
  logic                     in_frame;
  logic [CW-1:0]            origin;
  logic [CW:0]              ext_right;
  logic [CW:0]              ext_bottom;

  always_comb begin
    next_x      = {1'b0, st.cursor_x} + (CW+1)'(1);
    lim_x       = {1'b0, st.window_left} + {1'b0, st.window_extent};
    lim_y       = {1'b0, st.window_top} + {1'b0, st.window_extent};
    lp_inc      = {1'b0, st.linear_pointer} + 16'd1;
    cursor_addr = {8'd0, st.cursor_y} * 16'(FRAME_WIDTH) + {8'd0, st.cursor_x};
    in_frame    = ({1'b0, st.cursor_x} < (CW+1)'(FRAME_WIDTH)) &&
                  ({1'b0, st.cursor_y} < (CW+1)'(FRAME_HEIGHT));
    ext_right   = {1'b0, st.window_left} + {1'b0, item.value};
    ext_bottom  = {1'b0, st.window_top} + {1'b0, item.value};
    row_step    = st.cursor_y;
    origin      = '0;

    st_nxt = st;
    res    = '0;

    case (fbw_pkg::op_t'(item.op))
      fbw_pkg::OP_PIXEL: begin
        if (st.window_extent == '0) begin
          res.write_valid   = 1'b1;
          res.write_address = st.linear_pointer;
          res.write_data    = item.value;
          st_nxt.linear_pointer = (lp_inc >= 16'(FrameSize)) ? '0
                                                              : lp_inc[fbw_pkg::AddrW-1:0];
        end else begin
          if (in_frame) begin
            res.write_valid   = 1'b1;
            res.write_address = cursor_addr[fbw_pkg::AddrW-1:0];
            res.write_data    = item.value;
          end
          if (next_x >= lim_x) begin
            st_nxt.cursor_x = st.window_left;
            row_step        = st.cursor_y + CW'(1);
          end else begin
            st_nxt.cursor_x = next_x[CW-1:0];
          end
          st_nxt.cursor_y = ({1'b0, row_step} >= lim_y) ? st.window_top : row_step;
        end
      end
      fbw_pkg::OP_SET_COL: begin
        origin = ({1'b0, item.value} >= (CW+1)'(FRAME_WIDTH)) ? '0 : item.value;
        st_nxt.window_left = origin;
        st_nxt.cursor_x    = origin;
        st_nxt.cursor_y    = st.window_top;
      end
      fbw_pkg::OP_SET_ROW: begin
        origin = ({1'b0, item.value} >= (CW+1)'(FRAME_HEIGHT)) ? '0 : item.value;
        st_nxt.window_top = origin;
        st_nxt.cursor_y   = origin;
        st_nxt.cursor_x   = st.window_left;
      end
      fbw_pkg::OP_SET_EXTENT: begin
        if (ext_right > (CW+1)'(FRAME_WIDTH) || ext_bottom > (CW+1)'(FRAME_HEIGHT) ||
            item.value == '0) begin
          st_nxt.window_extent  = '0;
          st_nxt.linear_pointer = '0;
          res.clear_frame       = 1'b1;
        end else begin
          st_nxt.window_extent = item.value;
        end
        st_nxt.cursor_x = st.window_left;
        st_nxt.cursor_y = st.window_top;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

[src/fbw_checker.sv]
// ----------------------------------------------------------------------------
// fbw_checker: port checks for the window write port
// Concurrent assertions on the top level ports, attached with a bind.
// ----------------------------------------------------------------------------
module fbw_checker #(
  parameter int FRAME_WIDTH  = fbw_pkg::FrameWidthDefault,
  parameter int FRAME_HEIGHT = fbw_pkg::FrameHeightDefault
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      write_valid,
  input logic [fbw_pkg::AddrW-1:0] write_address,
  input logic [fbw_pkg::DataW-1:0] write_data,
  input logic                      clear_frame
);

  localparam int FrameSize = FRAME_WIDTH * FRAME_HEIGHT;

  // A stalled command must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(write_valid) &&
      $stable(write_address) && $stable(write_data) && $stable(clear_frame))
    else $error("command changed while stalled");

  // A command is a write, a clear or neither, never both.
  a_write_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(write_valid && clear_frame))
    else $error("write and clear in the same command");

  // Every issued write lands inside the frame.
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && write_valid |-> 32'(write_address) < 32'(FrameSize))
    else $error("write address past the frame");

  // A command without a write carries zero address and data.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !write_valid |-> write_address == '0 && write_data == '0)
    else $error("nonzero payload on a command without a write");

  // With nothing waiting at the output, the port takes a new transfer.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

endmodule

bind framebuffer_window_write_port fbw_checker #(
  .FRAME_WIDTH  (FRAME_WIDTH),
  .FRAME_HEIGHT (FRAME_HEIGHT)
) u_fbw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .write_valid   (out_bus.write_valid),
  .write_address (out_bus.write_address),
  .write_data    (out_bus.write_data),
  .clear_frame   (out_bus.clear_frame)
);
